/* hdl/drds_pkg.sv */
package drds_pkg;

   typedef enum logic [2:0] {
      OP_ADVANCE  = 3'd0,
      OP_COMPLETE = 3'd1,
      OP_CANCEL   = 3'd2,
      OP_INIT     = 3'd3,
      OP_READ     = 3'd4
   } op_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_STATE    = 2'd2;
   localparam logic [1:0] ST_ALREADY  = 2'd3;

   localparam logic CSR_INT_PERIOD   = 1'b0;
   localparam logic CSR_SCENE_PERIOD = 1'b1;

   localparam logic [2:0] SC_REGRESS   = 3'd0;
   localparam logic [2:0] SC_INT_DL    = 3'd1;
   localparam logic [2:0] SC_INT_TICK  = 3'd2;
   localparam logic [2:0] SC_INT_SKIP  = 3'd3;
   localparam logic [2:0] SC_SCN_DL    = 3'd4;
   localparam logic [2:0] SC_SCN_START = 3'd5;
   localparam logic [2:0] SC_SCN_REPL  = 3'd6;
   localparam logic [2:0] SC_SCN_DONE  = 3'd7;

   // sequencer: two divisions per due stream (elapsed count and headroom)
   typedef enum logic [3:0] {
      S_IDLE,
      S_I_DIV1, S_I_DIV2, S_I_FIN,
      S_S_DIV1, S_S_DIV2, S_S_FIN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

/* hdl/dual_rate_deadline_scheduler_core.sv */
// Advance runs two divisions per due stream on one shared radix-2 divider, the
// interaction stream first and then the scene stream; a stream that is not due
// skips both. Other ops answer in the cycle after accept.
// Throughput: one transaction at a time; busy stays high through the rsp_valid cycle.
// Each result shows for one cycle on rsp_valid; the receiver cannot stall.
// Synchronous active-high reset clears state, counters and periods to reset values.
module dual_rate_deadline_scheduler_core #(
   parameter int TIME_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [2:0]            req_op,
   input  logic [TIME_WIDTH-1:0] req_now_time,
   input  logic                  req_discard_pending,
   input  logic [2:0]            req_stat_select,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [TIME_WIDTH-1:0] csr_data,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic                  rsp_tick_due,
   output logic [TIME_WIDTH-1:0] rsp_interaction_time,
   output logic                  rsp_scene_go,
   output logic [TIME_WIDTH-1:0] rsp_scene_time,
   output logic [63:0]           rsp_stat_value
);
   localparam logic [TIME_WIDTH-1:0] TMAX = '1;

   drds_pkg::state_type st_ff, st_in;

   logic [TIME_WIDTH-1:0] ip_ff, sp_ff, lip_ff, lsp_ff;
   logic                  init_ff;
   logic [TIME_WIDTH-1:0] last_ff, ni_ff, ns_ff, pend_time_ff, now_ff;
   logic                  run_ff, pend_ff;
   logic [63:0]           stats_ff [8];
   logic [TIME_WIDTH-1:0] q1_ff, r1_ff;

   // response registers
   logic                  rv_ff, rv_in;
   logic [1:0]            rst_ff, rst_in;
   logic                  rid_ff, rss_ff;
   logic [TIME_WIDTH-1:0] rit_ff, rst_time_ff;
   logic [63:0]           rstat_ff;

   logic                  dstart;
   logic [TIME_WIDTH-1:0] dnd, dsr, dq, drem;
   drds_pkg::div_ctl_type dctl;

   logic                  accept, adv_go, promote;
   logic [TIME_WIDTH-1:0] per, nxt, newest, step;
   logic [TIME_WIDTH:0]   qp1;
   logic                  due;

   assign accept    = start && !busy;
   assign busy      = (st_ff != drds_pkg::S_IDLE) || rv_ff;
   assign csr_ready = 1'b1;

   // decode status of the incoming transaction
   always_comb begin
      rst_in = drds_pkg::ST_OK;
      case (req_op)
         drds_pkg::OP_ADVANCE: begin
            if (!init_ff) rst_in = drds_pkg::ST_STATE;
            else if (req_now_time < last_ff) rst_in = drds_pkg::ST_INVALID;
         end
         drds_pkg::OP_COMPLETE, drds_pkg::OP_CANCEL: begin
            if (!init_ff || !run_ff) rst_in = drds_pkg::ST_STATE;
         end
         drds_pkg::OP_INIT: begin
            if (init_ff) rst_in = drds_pkg::ST_ALREADY;
            else if (ip_ff == '0 || sp_ff == '0) rst_in = drds_pkg::ST_INVALID;
         end
         drds_pkg::OP_READ: rst_in = drds_pkg::ST_OK;
         default: rst_in = drds_pkg::ST_INVALID;
      endcase
      adv_go  = accept && req_op == drds_pkg::OP_ADVANCE && rst_in == drds_pkg::ST_OK;
      promote = rst_in == drds_pkg::ST_OK && pend_ff &&
                (req_op == drds_pkg::OP_COMPLETE ||
                 (req_op == drds_pkg::OP_CANCEL && !req_discard_pending));
      rv_in   = (accept && !adv_go) || st_ff == drds_pkg::S_DONE;
   end

   // stream operands by phase
   always_comb begin
      if (st_ff == drds_pkg::S_I_DIV1 || st_ff == drds_pkg::S_I_DIV2 ||
          st_ff == drds_pkg::S_I_FIN) begin
         per = (lip_ff == '0) ? TIME_WIDTH'(1) : lip_ff;
         nxt = ni_ff;
      end else begin
         per = (lsp_ff == '0) ? TIME_WIDTH'(1) : lsp_ff;
         nxt = ns_ff;
      end
      due    = now_ff >= nxt;
      qp1    = {1'b0, q1_ff} + 1'b1;
      // newest deadline is now minus the remainder; next one is a period later
      newest = now_ff - r1_ff;
      step   = newest + per;
   end

   // divider start, operands and next sequencer state
   always_comb begin
      dstart = 1'b0;
      dnd    = now_ff - nxt;
      dsr    = per;
      st_in  = st_ff;
      case (st_ff)
         drds_pkg::S_IDLE: begin
            if (adv_go) st_in = drds_pkg::S_I_DIV1;
         end
         drds_pkg::S_I_DIV1, drds_pkg::S_S_DIV1: begin
            if (!dctl.busy && !dctl.done) begin
               if (due) dstart = 1'b1;
               else st_in = (st_ff == drds_pkg::S_I_DIV1) ? drds_pkg::S_S_DIV1
                                                            : drds_pkg::S_DONE;
            end else if (dctl.done) begin
               dstart = 1'b1;
               dnd    = TMAX - nxt;
               st_in  = (st_ff == drds_pkg::S_I_DIV1) ? drds_pkg::S_I_DIV2
                                                       : drds_pkg::S_S_DIV2;
            end
         end
         drds_pkg::S_I_DIV2: if (dctl.done) st_in = drds_pkg::S_I_FIN;
         drds_pkg::S_S_DIV2: if (dctl.done) st_in = drds_pkg::S_S_FIN;
         drds_pkg::S_I_FIN: st_in = drds_pkg::S_S_DIV1;
         drds_pkg::S_S_FIN: st_in = drds_pkg::S_DONE;
         drds_pkg::S_DONE: st_in = drds_pkg::S_IDLE;
         default: st_in = drds_pkg::S_IDLE;
      endcase
   end

   drds_div #(.TIME_WIDTH(TIME_WIDTH)) u_div (
      .clock(clock), .reset(reset), .start(dstart),
      .dividend(dnd), .divisor(dsr), .ctl(dctl), .quotient(dq), .remainder(drem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= drds_pkg::S_IDLE;
         ip_ff   <= TIME_WIDTH'(1);
         sp_ff   <= TIME_WIDTH'(1);
         lip_ff  <= '0;
         lsp_ff  <= '0;
         init_ff <= 1'b0;
         last_ff <= '0;
         ni_ff   <= '0;
         ns_ff   <= '0;
         run_ff  <= 1'b0;
         pend_ff <= 1'b0;
         pend_time_ff <= '0;
         rv_ff   <= 1'b0;
         for (int i = 0; i < 8; i++) stats_ff[i] <= '0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
         // configuration writes
         if (csr_valid) begin
            if (csr_index == drds_pkg::CSR_INT_PERIOD) ip_ff <= csr_data;
            else sp_ff <= csr_data;
         end
         // hold first quotient and remainder
         if ((st_ff == drds_pkg::S_I_DIV1 || st_ff == drds_pkg::S_S_DIV1) && dctl.done) begin
            q1_ff <= dq;
            r1_ff <= drem;
         end
         if (accept) begin
            rst_ff      <= rst_in;
            rid_ff      <= 1'b0;
            rit_ff      <= '0;
            rss_ff      <= promote;
            rst_time_ff <= promote ? pend_time_ff : '0;
            rstat_ff    <= (req_op == drds_pkg::OP_READ) ? stats_ff[req_stat_select] : '0;
            now_ff      <= req_now_time;
            if (rst_in == drds_pkg::ST_OK) begin
               case (req_op)
                  drds_pkg::OP_ADVANCE: last_ff <= req_now_time;
                  drds_pkg::OP_COMPLETE: begin
                     stats_ff[drds_pkg::SC_SCN_DONE] <= stats_ff[drds_pkg::SC_SCN_DONE] + 1'b1;
                     if (pend_ff) begin
                        pend_ff <= 1'b0;
                        stats_ff[drds_pkg::SC_SCN_START] <=
                           stats_ff[drds_pkg::SC_SCN_START] + 1'b1;
                     end else run_ff <= 1'b0;
                  end
                  drds_pkg::OP_CANCEL: begin
                     if (req_discard_pending || !pend_ff) begin
                        run_ff  <= 1'b0;
                        pend_ff <= 1'b0;
                     end else begin
                        pend_ff <= 1'b0;
                        stats_ff[drds_pkg::SC_SCN_START] <=
                           stats_ff[drds_pkg::SC_SCN_START] + 1'b1;
                     end
                  end
                  drds_pkg::OP_INIT: begin
                     lip_ff  <= ip_ff;
                     lsp_ff  <= sp_ff;
                     last_ff <= req_now_time;
                     ni_ff   <= req_now_time;
                     ns_ff   <= req_now_time;
                     init_ff <= 1'b1;
                  end
                  default: begin
                  end
               endcase
            end else if (req_op == drds_pkg::OP_ADVANCE && rst_in == drds_pkg::ST_INVALID) begin
               // count the backwards time
               stats_ff[drds_pkg::SC_REGRESS] <= stats_ff[drds_pkg::SC_REGRESS] + 1'b1;
            end
         end
         // interaction stream commit
         if (st_ff == drds_pkg::S_I_FIN) begin
            rid_ff <= 1'b1;
            rit_ff <= newest;
            ni_ff  <= (q1_ff >= dq) ? TMAX : step;
            stats_ff[drds_pkg::SC_INT_DL] <= stats_ff[drds_pkg::SC_INT_DL] +
                                              64'(qp1);
            stats_ff[drds_pkg::SC_INT_TICK] <= stats_ff[drds_pkg::SC_INT_TICK] + 1'b1;
            stats_ff[drds_pkg::SC_INT_SKIP] <= stats_ff[drds_pkg::SC_INT_SKIP] +
                                                64'(q1_ff);
         end
         // scene stream commit
         if (st_ff == drds_pkg::S_S_FIN) begin
            ns_ff <= (q1_ff >= dq) ? TMAX : step;
            stats_ff[drds_pkg::SC_SCN_DL] <= stats_ff[drds_pkg::SC_SCN_DL] + 64'(qp1);
            if (!run_ff) begin
               rss_ff      <= 1'b1;
               rst_time_ff <= newest;
               run_ff      <= 1'b1;
               stats_ff[drds_pkg::SC_SCN_START] <= stats_ff[drds_pkg::SC_SCN_START] + 1'b1;
               stats_ff[drds_pkg::SC_SCN_REPL] <= stats_ff[drds_pkg::SC_SCN_REPL] +
                                                   64'(q1_ff);
            end else begin
               stats_ff[drds_pkg::SC_SCN_REPL] <= stats_ff[drds_pkg::SC_SCN_REPL] +
                                                   64'(q1_ff) + 64'(pend_ff);
               pend_time_ff <= newest;
               pend_ff      <= 1'b1;
            end
         end
      end
   end

   assign rsp_valid            = rv_ff;
   assign rsp_status           = rst_ff;
   assign rsp_tick_due         = rid_ff;
   assign rsp_interaction_time = rit_ff;
   assign rsp_scene_go         = rss_ff;
   assign rsp_scene_time       = rst_time_ff;
   assign rsp_stat_value       = rstat_ff;

   a_rsp_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response");
   a_pend_needs_run: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> run_ff) else $error("pending scene without running scene");
   a_run_needs_init: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> init_ff) else $error("scene running before init");

endmodule

/* hdl/drds_div.sv */
module drds_div #(
   parameter int TIME_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [TIME_WIDTH-1:0] dividend,
   input  logic [TIME_WIDTH-1:0] divisor,
   output drds_pkg::div_ctl_type ctl,
   output logic [TIME_WIDTH-1:0] quotient,
   output logic [TIME_WIDTH-1:0] remainder
);
   localparam int CW = $clog2(TIME_WIDTH + 1);

   logic [TIME_WIDTH-1:0] q_ff, q_in, d_ff, d_in;
   logic [TIME_WIDTH:0]   r_ff, r_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [TIME_WIDTH:0]   trial, diff;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial   = {r_ff[TIME_WIDTH-1:0], q_ff[TIME_WIDTH-1]};
      diff    = trial - {1'b0, d_ff};
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = CW'(TIME_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[TIME_WIDTH]) begin
            r_in = diff;
            q_in = {q_ff[TIME_WIDTH-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[TIME_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = q_ff;
   assign remainder = r_ff[TIME_WIDTH-1:0];
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("start while busy");
   a_busy_clears: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff || $past(start)) else $error("busy stuck after done");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

   localparam int TW = 64;
   localparam logic [63:0] ALL_ONES = '1;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic [2:0]  op;
      logic [63:0] now_time;
      logic        discard;
      logic [2:0]  sel;
   } sched_cmd_type;

   typedef struct {
      logic [1:0]  status;
      logic        int_due;
      logic [63:0] int_time;
      logic        scn_start;
      logic [63:0] scn_time;
      logic [63:0] stat;
   } sched_rsp_type;

   logic          clock = 0;
   logic          reset = 1;
   logic          start = 0;
   logic          busy;
   logic [2:0]    req_op = '0;
   logic [TW-1:0] req_now_time = '0;
   logic          req_discard_pending = 0;
   logic [2:0]    req_stat_select = '0;
   logic          csr_valid = 0;
   logic          csr_ready;
   logic [0:0]    csr_index = '0;
   logic [TW-1:0] csr_data = '0;
   logic          rsp_valid;
   logic [1:0]    rsp_status;
   logic          rsp_tick_due;
   logic [TW-1:0] rsp_interaction_time;
   logic          rsp_scene_go;
   logic [TW-1:0] rsp_scene_time;
   logic [63:0]   rsp_stat_value;

   dual_rate_deadline_scheduler_core #(.TIME_WIDTH(TW)) dut (.*);

   always #5 clock = ~clock;

   sched_cmd_type cmd_q[$];
   sched_rsp_type sched_expect_q[$];
   int            fail_count = 0;
   int            stall_cycles = 0;

   // scheduler shadow state and register copies
   logic [63:0] cfg_int_period = 1, cfg_scn_period = 1;
   logic [63:0] lat_int, lat_scn, last_now, nxt_int, nxt_scn, pend_time;
   logic        armed, running, pending;
   logic [63:0] counters[8];

   // step one stream; returns 1 when a deadline has fallen due
   function automatic bit elapse(input logic [63:0] now, input logic [63:0] period,
                                 inout logic [63:0] nxt, output logic [63:0] newest,
                                 output logic [63:0] skipped);
      logic [63:0] q, room;
      newest = 0;
      skipped = 0;
      if (period == 0) period = 1;
      if (now < nxt) return 0;
      q = (now - nxt) / period;
      newest = nxt + q * period;
      skipped = q;
      room = (ALL_ONES - nxt) / period;
      if (q >= room) nxt = ALL_ONES;
      else nxt = nxt + (q + 1) * period;
      return 1;
   endfunction

   function automatic sched_rsp_type schedule(input sched_cmd_type c);
      sched_rsp_type r;
      logic [63:0] newest, skipped;
      r = '{default: 0};
      r.status = drds_pkg::ST_OK;
      case (c.op)
         drds_pkg::OP_ADVANCE: begin
            if (!armed) r.status = drds_pkg::ST_STATE;
            else if (c.now_time < last_now) begin
               counters[drds_pkg::SC_REGRESS]++;
               r.status = drds_pkg::ST_INVALID;
            end else begin
               last_now = c.now_time;
               if (elapse(c.now_time, lat_int, nxt_int, newest, skipped)) begin
                  r.int_due = 1;
                  r.int_time = newest;
                  counters[drds_pkg::SC_INT_DL] += skipped + 1;
                  counters[drds_pkg::SC_INT_TICK]++;
                  counters[drds_pkg::SC_INT_SKIP] += skipped;
               end
               if (elapse(c.now_time, lat_scn, nxt_scn, newest, skipped)) begin
                  counters[drds_pkg::SC_SCN_DL] += skipped + 1;
                  counters[drds_pkg::SC_SCN_REPL] += skipped;
                  if (!running) begin
                     r.scn_start = 1;
                     r.scn_time = newest;
                     running = 1;
                     counters[drds_pkg::SC_SCN_START]++;
                  end else begin
                     if (pending) counters[drds_pkg::SC_SCN_REPL]++;
                     pend_time = newest;
                     pending = 1;
                  end
               end
            end
         end
         drds_pkg::OP_COMPLETE: begin
            if (!armed || !running) r.status = drds_pkg::ST_STATE;
            else begin
               counters[drds_pkg::SC_SCN_DONE]++;
               if (pending) begin
                  r.scn_start = 1;
                  r.scn_time = pend_time;
                  pending = 0;
                  counters[drds_pkg::SC_SCN_START]++;
               end else running = 0;
            end
         end
         drds_pkg::OP_CANCEL: begin
            if (!armed || !running) r.status = drds_pkg::ST_STATE;
            else if (c.discard || !pending) begin
               running = 0;
               pending = 0;
            end else begin
               r.scn_start = 1;
               r.scn_time = pend_time;
               pending = 0;
               counters[drds_pkg::SC_SCN_START]++;
            end
         end
         drds_pkg::OP_INIT: begin
            if (armed) r.status = drds_pkg::ST_ALREADY;
            else if (cfg_int_period == 0 || cfg_scn_period == 0)
               r.status = drds_pkg::ST_INVALID;
            else begin
               lat_int = cfg_int_period;
               lat_scn = cfg_scn_period;
               last_now = c.now_time;
               nxt_int = c.now_time;
               nxt_scn = c.now_time;
               armed = 1;
            end
         end
         drds_pkg::OP_READ: r.stat = counters[c.sel];
         default: r.status = drds_pkg::ST_INVALID;
      endcase
      return r;
   endfunction

   // driver: hold each transaction until accepted, then wait out the gap drawn with it
   int  gap_left = 0;
   bit  gappy = 1;
   always @(posedge clock) begin
      sched_cmd_type c;
      logic next_start;
      if (reset) begin
         start <= 0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            c.op = req_op;
            c.now_time = req_now_time;
            c.discard = req_discard_pending;
            c.sel = req_stat_select;
            sched_expect_q.push_back(schedule(c));
            next_start = 0;
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (cmd_q.size() > 0) begin
               c = cmd_q.pop_front();
               req_op <= c.op;
               req_now_time <= c.now_time;
               req_discard_pending <= c.discard;
               req_stat_select <= c.sel;
               next_start = 1;
               if ($urandom_range(0, 40) == 0) gappy = !gappy;
               gap_left = gappy ? $urandom_range(0, 12) : 0;
            end
         end
         start <= next_start;
      end
   end

   // monitor: compare each result against the oldest expectation
   always @(posedge clock) begin
      sched_rsp_type e;
      if (!reset && rsp_valid) begin
         if (sched_expect_q.size() == 0) begin
            $display("%0t: unexpected result, status %0d", $time, rsp_status);
            fail_count++;
         end else begin
            e = sched_expect_q.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_status);
               fail_count++;
            end
            if (rsp_tick_due !== e.int_due) begin
               $display("%0t: tick_due exp %0d got %0d", $time, e.int_due,
                        rsp_tick_due);
               fail_count++;
            end
            if (rsp_interaction_time !== e.int_time) begin
               $display("%0t: interaction_time exp %h got %h", $time, e.int_time,
                        rsp_interaction_time);
               fail_count++;
            end
            if (rsp_scene_go !== e.scn_start) begin
               $display("%0t: scene_go exp %0d got %0d", $time, e.scn_start,
                        rsp_scene_go);
               fail_count++;
            end
            if (rsp_scene_time !== e.scn_time) begin
               $display("%0t: scene_time exp %h got %h", $time, e.scn_time,
                        rsp_scene_time);
               fail_count++;
            end
            if (rsp_stat_value !== e.stat) begin
               $display("%0t: stat_value exp %h got %h", $time, e.stat, rsp_stat_value);
               fail_count++;
            end
         end
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic push_cmd(input logic [2:0] op, input logic [63:0] t,
                           input logic d = 0, input logic [2:0] s = 0);
      sched_cmd_type c;
      c.op = op;
      c.now_time = t;
      c.discard = d;
      c.sel = s;
      cmd_q.push_back(c);
   endtask

   task automatic csr_write(input logic idx, input logic [63:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      if (idx == drds_pkg::CSR_INT_PERIOD) cfg_int_period = val;
      else cfg_scn_period = val;
      csr_valid <= 0;
   endtask

   task automatic wait_idle();
      wait (cmd_q.size() == 0 && !start && sched_expect_q.size() == 0);
      repeat (300) @(posedge clock);
   endtask

   // random traffic around the current time; big_jumps walks the upper bits
   task automatic random_traffic(input int count, input bit big_jumps,
                                 inout logic [63:0] t);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            if (big_jumps && $urandom_range(0, 3) == 0)
               t = t + (rand64() >> $urandom_range(2, 63));
            else
               t = t + $urandom_range(0, 40);
            push_cmd(drds_pkg::OP_ADVANCE, t, 1'($urandom), 3'($urandom));
         end else if (r < 54) begin
            push_cmd(drds_pkg::OP_ADVANCE, t - $urandom_range(1, 50), 1'($urandom),
                     3'($urandom));
         end else if (r < 69)
            push_cmd(drds_pkg::OP_COMPLETE, rand64(), 1'($urandom), 3'($urandom));
         else if (r < 84)
            push_cmd(drds_pkg::OP_CANCEL, rand64(), 1'($urandom), 3'($urandom));
         else if (r < 94)
            push_cmd(drds_pkg::OP_READ, rand64(), 1'($urandom), 3'($urandom));
         else if (r < 97)
            push_cmd(drds_pkg::OP_INIT, rand64(), 1'($urandom), 3'($urandom));
         else
            push_cmd(3'($urandom_range(5, 7)), rand64(), 1'($urandom), 3'($urandom));
      end
   endtask

   initial begin
      logic [63:0] t;
      armed = 0;
      running = 0;
      pending = 0;
      last_now = 0;
      nxt_int = 0;
      nxt_scn = 0;
      pend_time = 0;
      lat_int = 0;
      lat_scn = 0;
      for (int i = 0; i < 8; i++) counters[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // before init: every op but read refused, unused codes rejected
      push_cmd(drds_pkg::OP_ADVANCE, ALL_ONES);
      push_cmd(drds_pkg::OP_COMPLETE, 0);
      push_cmd(drds_pkg::OP_CANCEL, 0, 1);
      for (int s = 0; s < 8; s++) push_cmd(drds_pkg::OP_READ, 0, 0, s[2:0]);
      push_cmd(3'd5, 0);
      push_cmd(3'd6, ALL_ONES);
      push_cmd(3'd7, 0);
      wait_idle();

      // zero periods rejected at init
      csr_write(drds_pkg::CSR_INT_PERIOD, 0);
      push_cmd(drds_pkg::OP_INIT, 5);
      wait_idle();
      csr_write(drds_pkg::CSR_INT_PERIOD, ALL_ONES);
      csr_write(drds_pkg::CSR_SCENE_PERIOD, 0);
      push_cmd(drds_pkg::OP_INIT, 5);
      wait_idle();

      // arm with small periods so deadlines fall often
      csr_write(drds_pkg::CSR_INT_PERIOD, $urandom_range(1, 8));
      csr_write(drds_pkg::CSR_SCENE_PERIOD, $urandom_range(1, 16));
      t = $urandom_range(0, 100);
      push_cmd(drds_pkg::OP_INIT, t);
      push_cmd(drds_pkg::OP_INIT, t);
      push_cmd(drds_pkg::OP_ADVANCE, t);
      push_cmd(drds_pkg::OP_ADVANCE, t + 3);
      push_cmd(drds_pkg::OP_ADVANCE, t + 40);
      push_cmd(drds_pkg::OP_ADVANCE, t + 1);
      push_cmd(drds_pkg::OP_CANCEL, 0, 0);
      push_cmd(drds_pkg::OP_COMPLETE, 0);
      t = t + 40;
      random_traffic(1000, 0, t);
      wait_idle();

      // registers only matter at init now, which reports already initialized
      csr_write(drds_pkg::CSR_INT_PERIOD, rand64());
      csr_write(drds_pkg::CSR_SCENE_PERIOD, 0);
      push_cmd(drds_pkg::OP_INIT, 0);
      random_traffic(900, 1, t);
      wait_idle();

      // saturation: advance to all ones, repeat at all ones, step back once, read every counter
      csr_write(drds_pkg::CSR_SCENE_PERIOD, ALL_ONES);
      push_cmd(drds_pkg::OP_ADVANCE, ALL_ONES);
      push_cmd(drds_pkg::OP_ADVANCE, ALL_ONES);
      push_cmd(drds_pkg::OP_COMPLETE, 0);
      push_cmd(drds_pkg::OP_ADVANCE, ALL_ONES);
      push_cmd(drds_pkg::OP_CANCEL, 0, 1);
      push_cmd(drds_pkg::OP_ADVANCE, ALL_ONES);
      push_cmd(drds_pkg::OP_ADVANCE, ALL_ONES - 1);
      for (int s = 0; s < 8; s++) push_cmd(drds_pkg::OP_READ, 0, 0, s[2:0]);
      wait_idle();

      if (sched_expect_q.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, sched_expect_q.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
